@@ rtl/qss_pkg.sv @@
// qss_pkg: shared types and codes of the queue-stack store
// no dependencies; used by qss_cell and queue_stack_store_core
`timescale 1ns / 1ps

package qss_pkg;

   localparam int OP_W     = 3;
   localparam int WORD_W   = 32;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 3'd0,
      OP_PUSH   = 3'd1,
      OP_POP    = 3'd2,
      OP_TOP    = 3'd3,
      OP_READ   = 3'd4,
      OP_WRITE  = 3'd5,
      OP_MEMBER = 3'd6,
      OP_TRUNC  = 3'd7
   } op_type;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [WORD_W-1:0] datum;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   value;
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    length;
   } rsp_type;

   // broadcast controls from the top level to every cell
   typedef struct packed {
      logic push_en;
      logic pop_en;
      logic store_en;
      logic scan_read;
      logic scan_member;
   } cell_ctl_type;

endpackage

@@ rtl/qss_cell.sv @@
// qss_cell: one slot of the queue-stack row plus one stage of the scan chain
// depends on qss_pkg (cell_ctl_type)
`timescale 1ns / 1ps

module qss_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int CAPACITY   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(CAPACITY)-1:0]     cell_index,
   input  qss_pkg::cell_ctl_type           ctl,
   input  logic [$clog2(CAPACITY+1)-1:0]   count,
   input  logic [DATA_WIDTH-1:0]           upd_word,
   input  logic [$clog2(CAPACITY)-1:0]     upd_target,
   input  logic [DATA_WIDTH-1:0]           cmp_word,
   input  logic [$clog2(CAPACITY)-1:0]     cmp_target,
   input  logic [DATA_WIDTH-1:0]           left_entry,
   input  logic [DATA_WIDTH-1:0]           right_entry,
   output logic [DATA_WIDTH-1:0]           entry_out,
   input  logic                            scan_valid_in,
   input  logic                            scan_hit_in,
   input  logic [DATA_WIDTH-1:0]           scan_data_in,
   output logic                            scan_valid_out,
   output logic                            scan_hit_out,
   output logic [DATA_WIDTH-1:0]           scan_data_out
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic                  scan_valid_ff;
   logic                  scan_hit_ff, scan_hit_in_w;
   logic [DATA_WIDTH-1:0] scan_data_ff, scan_data_in_w;
   logic                  local_hit;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push_en) begin
         entry_in = (cell_index == '0) ? upd_word : left_entry;
      end else if (ctl.pop_en) begin
         entry_in = right_entry;
      end else if (ctl.store_en && (cell_index == upd_target)) begin
         entry_in = upd_word;
      end
   end

   // local match, only inside the live part of the row for membership
   always_comb begin
      local_hit = 1'b0;
      if (ctl.scan_read) begin
         local_hit = (cell_index == cmp_target);
      end else if (ctl.scan_member) begin
         local_hit = (CNT_W'(cell_index) < count) && (entry_ff == cmp_word);
      end
      scan_hit_in_w  = scan_hit_in | local_hit;
      scan_data_in_w = (local_hit && !scan_hit_in) ? entry_ff : scan_data_in;
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      scan_hit_ff  <= scan_hit_in_w;
      scan_data_ff <= scan_data_in_w;
      if (reset) begin
         scan_valid_ff <= 1'b0;
      end else begin
         scan_valid_ff <= scan_valid_in;
      end
   end

   assign entry_out      = entry_ff;
   assign scan_valid_out = scan_valid_ff;
   assign scan_hit_out   = scan_hit_ff;
   assign scan_data_out  = scan_data_ff;

endmodule

@@ rtl/queue_stack_store_core.sv @@
// queue_stack_store_core: top level of the bounded queue-stack store
// depends on qss_pkg and qss_cell
`timescale 1ns / 1ps

// A bounded queue-stack of CAPACITY words held in a row of cells, head in
// cell 0. A command transfer happens at a rising edge with start high and
// busy low; its single result is shown on rsp_item for exactly one cycle
// with rsp_strobe high, starting the cycle after the command is accepted
// for append, push, pop, top, write nth and truncate. Those commands may
// follow each other in every cycle. Read nth (in range) and member instead
// send a scan token down the cell row, one cell per cycle: busy is high
// while the token walks the row, so no new command is accepted until the
// scan result has been registered for rsp_item. The result port has no
// back-pressure: the receiver must take every strobe. Entries never written
// hold unknown data but are never observed through the ports.
module queue_stack_store_core #(
   parameter int CAPACITY   = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  qss_pkg::req_type req_item,
   output logic             rsp_strobe,
   output qss_pkg::rsp_type rsp_item
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > qss_pkg::POS_W) ? CNT_W : qss_pkg::POS_W;

   // command transfer
   logic            accept;
   qss_pkg::op_type op;
   logic [DATA_WIDTH-1:0] word;
   logic [CMP_W-1:0]      pos_ext, count_ext;
   logic                  is_empty, is_full, pos_bad;

   // state
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  scan_active_ff, scan_active_in;
   logic                  scan_start_ff, scan_start_in;
   logic                  query_read_ff, query_read_in;
   logic                  query_member_ff, query_member_in;
   logic [DATA_WIDTH-1:0] query_word_ff, query_word_in;
   logic [IDX_W-1:0]      query_target_ff, query_target_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   qss_pkg::rsp_type      rsp_ff, rsp_in;

   // broadcast to the cell row
   qss_pkg::cell_ctl_type cell_ctl;
   logic [IDX_W-1:0]      upd_target;

   // row wiring
   logic [DATA_WIDTH-1:0] entry_w     [CAPACITY];
   logic                  scan_valid_w[CAPACITY+1];
   logic                  scan_hit_w  [CAPACITY+1];
   logic [DATA_WIDTH-1:0] scan_data_w [CAPACITY+1];

   assign busy   = scan_active_ff;
   assign accept = start && !scan_active_ff;

   assign op        = qss_pkg::op_type'(req_item.operation);
   assign word      = DATA_WIDTH'(req_item.datum);
   assign pos_ext   = CMP_W'(req_item.position);
   assign count_ext = CMP_W'(count_ff);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   // position 0 or past the tail; past the tail also covers past capacity
   assign pos_bad   = (pos_ext == '0) || (pos_ext > count_ext);

   // decode accepted commands into row controls and the result; also return the result of a finished scan
   always_comb begin
      cell_ctl          = '0;
      upd_target        = IDX_W'(count_ff);
      count_in          = count_ff;
      scan_active_in    = scan_active_ff;
      scan_start_in     = 1'b0;
      query_read_in     = query_read_ff;
      query_member_in   = query_member_ff;
      query_word_in     = query_word_ff;
      query_target_in   = query_target_ff;
      rsp_strobe_in     = 1'b0;
      rsp_in            = rsp_ff;

      if (accept) begin
         rsp_strobe_in = 1'b1;
         rsp_in.value  = '0;
         rsp_in.status = qss_pkg::STATUS_OK;
         case (op)
            qss_pkg::OP_APPEND: begin
               if (is_full) begin
                  rsp_in.status = qss_pkg::STATUS_FULL;
               end else begin
                  cell_ctl.store_en = 1'b1;
                  upd_target        = IDX_W'(count_ff);
                  count_in          = count_ff + 1'b1;
               end
            end
            qss_pkg::OP_PUSH: begin
               if (is_full) begin
                  rsp_in.status = qss_pkg::STATUS_FULL;
               end else begin
                  cell_ctl.push_en = 1'b1;
                  count_in         = count_ff + 1'b1;
               end
            end
            qss_pkg::OP_POP: begin
               if (is_empty) begin
                  rsp_in.status = qss_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.value    = qss_pkg::WORD_W'(entry_w[0]);
                  cell_ctl.pop_en = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
            qss_pkg::OP_TOP: begin
               if (is_empty) begin
                  rsp_in.status = qss_pkg::STATUS_EMPTY;
               end else begin
                  rsp_in.value = qss_pkg::WORD_W'(entry_w[0]);
               end
            end
            qss_pkg::OP_WRITE: begin
               if (pos_bad) begin
                  rsp_in.status = qss_pkg::STATUS_INDEX;
               end else begin
                  cell_ctl.store_en = 1'b1;
                  upd_target        = IDX_W'(pos_ext - 1'b1);
               end
            end
            qss_pkg::OP_READ: begin
               if (pos_bad) begin
                  rsp_in.status = qss_pkg::STATUS_INDEX;
               end else begin
                  // result comes back at the end of the row
                  rsp_strobe_in   = 1'b0;
                  scan_active_in  = 1'b1;
                  scan_start_in   = 1'b1;
                  query_read_in   = 1'b1;
                  query_member_in = 1'b0;
                  query_target_in = IDX_W'(pos_ext - 1'b1);
               end
            end
            qss_pkg::OP_MEMBER: begin
               rsp_strobe_in   = 1'b0;
               scan_active_in  = 1'b1;
               scan_start_in   = 1'b1;
               query_read_in   = 1'b0;
               query_member_in = 1'b1;
               query_word_in   = word;
            end
            qss_pkg::OP_TRUNC: begin
               if (pos_ext < count_ext) begin
                  count_in = CNT_W'(pos_ext);
               end
            end
            default: begin
               rsp_in.status = qss_pkg::STATUS_OK;
            end
         endcase
         rsp_in.length = qss_pkg::POS_W'(count_in);
      end else if (scan_valid_w[CAPACITY]) begin
         // scan token left the last cell
         scan_active_in = 1'b0;
         rsp_strobe_in  = 1'b1;
         rsp_in.length  = qss_pkg::POS_W'(count_ff);
         if (query_read_ff) begin
            rsp_in.value  = qss_pkg::WORD_W'(scan_data_w[CAPACITY]);
            rsp_in.status = qss_pkg::STATUS_OK;
         end else begin
            rsp_in.value  = '0;
            rsp_in.status = scan_hit_w[CAPACITY] ? qss_pkg::STATUS_OK
                                                 : qss_pkg::STATUS_EMPTY;
         end
      end

      // scan controls hold steady while the token walks the row
      cell_ctl.scan_read   = query_read_ff && scan_active_ff;
      cell_ctl.scan_member = query_member_ff && scan_active_ff;
   end

   always_ff @(posedge clock) begin
      query_word_ff   <= query_word_in;
      query_target_ff <= query_target_in;
      rsp_ff          <= rsp_in;
      if (reset) begin
         count_ff        <= '0;
         scan_active_ff  <= 1'b0;
         scan_start_ff   <= 1'b0;
         query_read_ff   <= 1'b0;
         query_member_ff <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         count_ff        <= count_in;
         scan_active_ff  <= scan_active_in;
         scan_start_ff   <= scan_start_in;
         query_read_ff   <= query_read_in;
         query_member_ff <= query_member_in;
         rsp_strobe_ff   <= rsp_strobe_in;
      end
   end

   // head of the scan chain
   assign scan_valid_w[0] = scan_start_ff;
   assign scan_hit_w[0]   = 1'b0;
   assign scan_data_w[0]  = '0;

   // the row of cells: entries shift between neighbors, scan flows head to tail
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_entry, right_entry;

      if (i == 0) begin : g_head
         assign left_entry = '0;
      end else begin : g_mid
         assign left_entry = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entry_w[i+1];
      end

      qss_cell #(
         .DATA_WIDTH(DATA_WIDTH),
         .CAPACITY  (CAPACITY)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_index    (IDX_W'(i)),
         .ctl           (cell_ctl),
         .count         (count_ff),
         .upd_word      (word),
         .upd_target    (upd_target),
         .cmp_word      (query_word_ff),
         .cmp_target    (query_target_ff),
         .left_entry    (left_entry),
         .right_entry   (right_entry),
         .entry_out     (entry_w[i]),
         .scan_valid_in (scan_valid_w[i]),
         .scan_hit_in   (scan_hit_w[i]),
         .scan_data_in  (scan_data_w[i]),
         .scan_valid_out(scan_valid_w[i+1]),
         .scan_hit_out  (scan_hit_w[i+1]),
         .scan_data_out (scan_data_w[i+1])
      );
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
